FILE: rtl/core/trm_pkg.sv
package trm_pkg;

   // Datapath and register file geometry
   localparam int DATA_W  = 32;
   localparam int REG_CNT = 16;
   localparam int REG_W   = $clog2(REG_CNT);
   localparam int STEP_W  = $clog2(DATA_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

   // Opcodes
   localparam logic [7:0] OP_WRITE = 8'h10;
   localparam logic [7:0] OP_MOV   = 8'h11;
   localparam logic [7:0] OP_MOVLI = 8'h12;
   localparam logic [7:0] OP_MOVHI = 8'h13;
   localparam logic [7:0] OP_ADD   = 8'h21;
   localparam logic [7:0] OP_ADDI  = 8'h31;
   localparam logic [7:0] OP_SUB   = 8'h22;
   localparam logic [7:0] OP_SUBI  = 8'h32;
   localparam logic [7:0] OP_MUL   = 8'h23;
   localparam logic [7:0] OP_MULI  = 8'h33;
   localparam logic [7:0] OP_DIV   = 8'h24;
   localparam logic [7:0] OP_DIVI  = 8'h34;

   // Response status codes
   localparam logic [2:0] ST_EXEC    = 3'd0;
   localparam logic [2:0] ST_WRITE   = 3'd1;
   localparam logic [2:0] ST_UNSUP   = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;

   // Shared arithmetic unit operations
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

endpackage

FILE: rtl/core/trm_ram.sv
module trm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

FILE: rtl/core/trm_alu.sv
module trm_alu (
   input  logic                clock,
   input  logic                reset,
   input  trm_pkg::alu_req_type alu_req,
   input  logic [31:0]         opnd_a,
   input  logic [31:0]         opnd_b,
   output logic                done,
   output logic [31:0]         result
);
   import trm_pkg::*;

   typedef enum logic [2:0] {
      A_IDLE,
      A_NEGA,
      A_NEGB,
      A_ITER,
      A_FIX
   } alu_state_type;

   alu_state_type       state_ff;
   alu_op_type          op_ff;
   logic [DATA_W-1:0]   a_ff;      // addend, multiplicand, or dividend/quotient
   logic [DATA_W-1:0]   b_ff;      // addend, multiplier, or divisor
   logic [DATA_W-1:0]   acc_ff;    // product accumulator or partial remainder
   logic [STEP_W-1:0]   cnt_ff;
   logic                neg_ff;
   logic                done_ff;
   logic [DATA_W-1:0]   result_ff;

   logic [DATA_W:0]     add_x;
   logic [DATA_W:0]     add_y;
   logic                add_inv;
   logic [DATA_W+1:0]   add_sum;
   logic                no_borrow;

   // Operand select for the one shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_inv = 1'b0;
      unique case (state_ff)
         A_IDLE: begin
         end
         A_NEGA: begin
            add_y   = {1'b0, a_ff};
            add_inv = 1'b1;
         end
         A_NEGB: begin
            add_y   = {1'b0, b_ff};
            add_inv = 1'b1;
         end
         A_ITER: begin
            unique case (op_ff)
               ALU_ADD: begin
                  add_x = {1'b0, a_ff};
                  add_y = {1'b0, b_ff};
               end
               ALU_SUB: begin
                  add_x   = {1'b0, a_ff};
                  add_y   = {1'b0, b_ff};
                  add_inv = 1'b1;
               end
               ALU_MUL: begin
                  add_x = {1'b0, acc_ff};
                  add_y = {1'b0, a_ff};
               end
               ALU_DIV: begin
                  // shifted remainder minus divisor
                  add_x   = {acc_ff, a_ff[DATA_W-1]};
                  add_y   = {1'b0, b_ff};
                  add_inv = 1'b1;
               end
               default: begin
               end
            endcase
         end
         A_FIX: begin
            add_y   = {1'b0, a_ff};
            add_inv = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign add_sum   = {1'b0, add_x} + {1'b0, (add_inv ? ~add_y : add_y)}
                      + {{(DATA_W+1){1'b0}}, add_inv};
   assign no_borrow = add_sum[DATA_W+1];

   // Sequencer: add/sub in one step, shift-add multiply and restoring
   // divide one bit per step; done pulses for one cycle back in idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            A_IDLE: begin
               done_ff <= 1'b0;
               if (alu_req.start) begin
                  op_ff  <= alu_req.op;
                  a_ff   <= opnd_a;
                  b_ff   <= opnd_b;
                  acc_ff <= '0;
                  cnt_ff <= '0;
                  neg_ff <= opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
                  state_ff <= (alu_req.op == ALU_DIV) ? A_NEGA : A_ITER;
               end
            end
            A_NEGA: begin
               if (a_ff[DATA_W-1]) begin
                  a_ff <= add_sum[DATA_W-1:0];
               end
               state_ff <= A_NEGB;
            end
            A_NEGB: begin
               if (b_ff[DATA_W-1]) begin
                  b_ff <= add_sum[DATA_W-1:0];
               end
               state_ff <= A_ITER;
            end
            A_ITER: begin
               unique case (op_ff)
                  ALU_ADD, ALU_SUB: begin
                     result_ff <= add_sum[DATA_W-1:0];
                     done_ff   <= 1'b1;
                     state_ff  <= A_IDLE;
                  end
                  ALU_MUL: begin
                     if (b_ff[0]) begin
                        acc_ff <= add_sum[DATA_W-1:0];
                     end
                     a_ff   <= {a_ff[DATA_W-2:0], 1'b0};
                     b_ff   <= {1'b0, b_ff[DATA_W-1:1]};
                     cnt_ff <= cnt_ff + 1'b1;
                     if (cnt_ff == LAST_STEP) begin
                        result_ff <= b_ff[0] ? add_sum[DATA_W-1:0] : acc_ff;
                        done_ff   <= 1'b1;
                        state_ff  <= A_IDLE;
                     end
                  end
                  ALU_DIV: begin
                     if (no_borrow) begin
                        acc_ff <= add_sum[DATA_W-1:0];
                     end else begin
                        acc_ff <= {acc_ff[DATA_W-2:0], a_ff[DATA_W-1]};
                     end
                     a_ff   <= {a_ff[DATA_W-2:0], no_borrow};
                     cnt_ff <= cnt_ff + 1'b1;
                     if (cnt_ff == LAST_STEP) begin
                        state_ff <= A_FIX;
                     end
                  end
                  default: begin
                     state_ff <= A_IDLE;
                  end
               endcase
            end
            A_FIX: begin
               // restore the quotient sign
               result_ff <= neg_ff ? add_sum[DATA_W-1:0] : a_ff;
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

FILE: rtl/core/tiny_register_machine_executor.sv
// Tiny register machine executor.
// Request channel (req_valid/req_ready): one 32-bit instruction plus a
// last-of-program flag. Response channel (rsp_valid/rsp_ready): one status
// and one signed value for every request, in order.
// The block takes one request at a time; req_ready is high only while the
// sequencer is idle. Work between acceptance and the response register:
//   halted, WRITE, MOV, OR-in, unknown opcode, zero divisor: no arithmetic unit
//   ADD, SUB: one pass through the shared adder
//   MUL: shift-add, one multiplier bit per cycle in the shared adder
//   DIV: sign fix-up steps plus one quotient bit per cycle
// The shared 34-bit adder in trm_alu carries the multiply and divide steps.
// A finished response sits in an output register, so a new request is taken
// while it waits; if the receiver stalls and a second response is ready, the
// sequencer holds it until the output register frees.
// Reset (synchronous) empties the register file (all registers read zero),
// clears the halt and drops rsp_valid. A request with the last flag set
// clears the registers and the halt the same way once it is answered.
module tiny_register_machine_executor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instruction,
   input  logic               req_last_of_program,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_value
);
   import trm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WAIT,
      S_DONE
   } seq_state_type;

   seq_state_type            state_ff;
   logic [DATA_W-1:0]        ins_ff;
   logic                     last_ff;
   logic [REG_W-1:0]         addr_b_ff;
   logic [REG_CNT-1:0]       valid_ff;
   logic                     halted_ff;
   logic [2:0]               status_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic                     wr_ff;
   logic [DATA_W-1:0]        wdata_ff;
   logic                     rsp_valid_ff;
   logic [2:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;

   logic [7:0]               req_op;
   logic [REG_W-1:0]         addr_b_in;
   logic [DATA_W-1:0]        ram_a;
   logic [DATA_W-1:0]        ram_b;
   logic [7:0]               op;
   logic [REG_W-1:0]         dst;
   logic [REG_W-1:0]         src;
   logic [15:0]              imm;
   logic [DATA_W-1:0]        ra;
   logic [DATA_W-1:0]        rb;
   logic [DATA_W-1:0]        opnd_b;
   logic                     is_alu;
   logic                     use_imm;
   alu_op_type               dec_op;
   logic                     div_zero;
   alu_req_type              alu_req;
   logic                     alu_done;
   logic [DATA_W-1:0]        alu_result;
   logic                     slot_free;
   logic                     ram_wr;

   // Second read port holds the destination for WRITE and OR-in, else reg3
   assign req_op = req_instruction[31:24];
   always_comb begin
      case (req_op) inside
         OP_WRITE, OP_MOVLI, OP_MOVHI: addr_b_in = req_instruction[23:20];
         default:                      addr_b_in = req_instruction[3:0];
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign ram_wr    = (state_ff == S_DONE) && slot_free && wr_ff && !last_ff;

   trm_ram #(
      .WIDTH(DATA_W),
      .DEPTH(REG_CNT)
   ) u_regs (
      .clock    (clock),
      .wr_en    (ram_wr),
      .wr_addr  (dst),
      .wr_data  (wdata_ff),
      .rd_addr_a(req_instruction[19:16]),
      .rd_data_a(ram_a),
      .rd_addr_b(addr_b_in),
      .rd_data_b(ram_b)
   );

   // Instruction fields; never-written registers read as zero
   assign op  = ins_ff[31:24];
   assign dst = ins_ff[23:20];
   assign src = ins_ff[19:16];
   assign imm = ins_ff[15:0];
   assign ra  = valid_ff[src] ? ram_a : '0;
   assign rb  = valid_ff[addr_b_ff] ? ram_b : '0;

   // Arithmetic decode
   always_comb begin
      is_alu  = 1'b1;
      use_imm = 1'b0;
      dec_op  = ALU_ADD;
      unique case (op) inside
         OP_ADD:  dec_op = ALU_ADD;
         OP_ADDI: begin dec_op = ALU_ADD; use_imm = 1'b1; end
         OP_SUB:  dec_op = ALU_SUB;
         OP_SUBI: begin dec_op = ALU_SUB; use_imm = 1'b1; end
         OP_MUL:  dec_op = ALU_MUL;
         OP_MULI: begin dec_op = ALU_MUL; use_imm = 1'b1; end
         OP_DIV:  dec_op = ALU_DIV;
         OP_DIVI: begin dec_op = ALU_DIV; use_imm = 1'b1; end
         default: is_alu = 1'b0;
      endcase
   end

   assign opnd_b   = use_imm ? {16'd0, imm} : rb;
   assign div_zero = (dec_op == ALU_DIV) && (opnd_b == '0);

   assign alu_req.start = (state_ff == S_READ) && !halted_ff && is_alu && !div_zero;
   assign alu_req.op    = dec_op;

   trm_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .alu_req(alu_req),
      .opnd_a (ra),
      .opnd_b (opnd_b),
      .done   (alu_done),
      .result (alu_result)
   );

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_ff        <= 1'b0;
      end else begin
         // load a finished response, drop it once taken
         if ((state_ff == S_DONE) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ins_ff    <= req_instruction;
                  last_ff   <= req_last_of_program;
                  addr_b_ff <= addr_b_in;
                  state_ff  <= S_READ;
               end
            end
            S_READ: begin
               if (halted_ff) begin
                  status_ff <= ST_IGNORED;
                  value_ff  <= '0;
                  wr_ff     <= 1'b0;
                  state_ff  <= S_DONE;
               end else begin
                  unique case (op) inside
                     OP_WRITE: begin
                        status_ff <= ST_WRITE;
                        value_ff  <= rb;
                        wr_ff     <= 1'b0;
                        state_ff  <= S_DONE;
                     end
                     OP_MOV: begin
                        status_ff <= ST_EXEC;
                        value_ff  <= '0;
                        wr_ff     <= 1'b1;
                        wdata_ff  <= ra;
                        state_ff  <= S_DONE;
                     end
                     OP_MOVLI: begin
                        status_ff <= ST_EXEC;
                        value_ff  <= '0;
                        wr_ff     <= 1'b1;
                        wdata_ff  <= rb | {16'd0, imm};
                        state_ff  <= S_DONE;
                     end
                     OP_MOVHI: begin
                        status_ff <= ST_EXEC;
                        value_ff  <= '0;
                        wr_ff     <= 1'b1;
                        wdata_ff  <= rb | {imm, 16'd0};
                        state_ff  <= S_DONE;
                     end
                     default: begin
                        value_ff <= '0;
                        wr_ff    <= 1'b0;
                        if (!is_alu) begin
                           status_ff <= ST_UNSUP;
                           halted_ff <= 1'b1;
                           state_ff  <= S_DONE;
                        end else if (div_zero) begin
                           status_ff <= ST_DIVZERO;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= ST_EXEC;
                           state_ff  <= S_WAIT;
                        end
                     end
                  endcase
               end
            end
            S_WAIT: begin
               if (alu_done) begin
                  wr_ff    <= 1'b1;
                  wdata_ff <= alu_result;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_value_ff  <= value_ff;
                  // end of program: empty the register file and clear the halt
                  if (last_ff) begin
                     valid_ff  <= '0;
                     halted_ff <= 1'b0;
                  end else if (wr_ff) begin
                     valid_ff[dst] <= 1'b1;
                  end
                  wr_ff    <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

FILE: sim/tiny_register_machine_executor_tb.sv
module tiny_register_machine_executor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trm_pkg::*;

   // One expected response
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
   } trm_result_type;

   // Shadow register machine plus queue of responses still owed by the block
   class trm_result_tracker;
      logic [31:0] regs [REG_CNT];
      bit          halted;
      trm_result_type pending_results [$];
      int          errors;

      function new();
         clear_machine();
         errors = 0;
      endfunction

      function void clear_machine();
         foreach (regs[i]) regs[i] = '0;
         halted = 1'b0;
      endfunction

      // Signed divide truncating toward zero; most negative / -1 wraps
      function logic [31:0] signed_quotient(logic [31:0] num, logic [31:0] den);
         logic [31:0] mag_n, mag_d, quot;
         mag_n = num[31] ? -num : num;
         mag_d = den[31] ? -den : den;
         quot  = mag_n / mag_d;
         return (num[31] ^ den[31]) ? -quot : quot;
      endfunction

      // Execute an accepted request on the shadow machine, queue its response
      function void note_request(logic [31:0] instr, logic last);
         logic [7:0]  opcode;
         logic [3:0]  rd, rs;
         logic [31:0] src_val, reg3_val, imm;
         trm_result_type res;
         opcode   = instr[31:24];
         rd       = instr[23:20];
         rs       = instr[19:16];
         imm      = {16'h0000, instr[15:0]};
         src_val  = regs[rs];
         reg3_val = regs[instr[3:0]];
         res.status = ST_EXEC;
         res.value  = '0;
         if (halted) begin
            res.status = ST_IGNORED;
         end else begin
            case (opcode)
               OP_WRITE: begin
                  res.status = ST_WRITE;
                  res.value  = regs[rd];
               end
               OP_MOV:   regs[rd] = src_val;
               OP_MOVLI: regs[rd] = regs[rd] | imm;
               OP_MOVHI: regs[rd] = regs[rd] | (imm << 16);
               OP_ADD:   regs[rd] = src_val + reg3_val;
               OP_ADDI:  regs[rd] = src_val + imm;
               OP_SUB:   regs[rd] = src_val - reg3_val;
               OP_SUBI:  regs[rd] = src_val - imm;
               OP_MUL:   regs[rd] = src_val * reg3_val;
               OP_MULI:  regs[rd] = src_val * imm;
               OP_DIV: begin
                  if (reg3_val == 0) res.status = ST_DIVZERO;
                  else regs[rd] = signed_quotient(src_val, reg3_val);
               end
               OP_DIVI: begin
                  if (imm == 0) res.status = ST_DIVZERO;
                  else regs[rd] = signed_quotient(src_val, imm);
               end
               default: begin
                  res.status = ST_UNSUP;
                  halted     = 1'b1;
               end
            endcase
         end
         if (last) clear_machine();
         pending_results.push_back(res);
      endfunction

      // Compare a response against the oldest outstanding expectation
      function void check_response(logic [2:0] status, logic [31:0] value);
         trm_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("response with no request outstanding: status %0d value %h",
                        status, value);
            return;
         end
         want = pending_results.pop_front();
         if (status !== want.status || value !== want.value) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected status %0d value %h, got status %0d value %h",
                        want.status, want.value, status, value);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [31:0] req_instruction     = '0;
   logic        req_last_of_program = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [2:0]  rsp_status;
   logic signed [31:0] rsp_value;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_left          = 0;

   logic [7:0] known_ops [12] = '{OP_WRITE, OP_MOV, OP_MOVLI, OP_MOVHI, OP_ADD, OP_ADDI,
                                  OP_SUB, OP_SUBI, OP_MUL, OP_MULI, OP_DIV, OP_DIVI};

   trm_result_tracker tracker = new();

   tiny_register_machine_executor u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_instruction     (req_instruction),
      .req_last_of_program (req_last_of_program),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_value           (rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, or a long hold-off when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response(rsp_status, rsp_value);
   end

   // Overall time limit
   initial begin
      #6_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [31:0] encode(logic [7:0] opcode, int rd, int rs,
                                           logic [15:0] low);
      logic [3:0] d, s;
      d = 4'(rd);
      s = 4'(rs);
      return {opcode, d, s, low};
   endfunction

   // Mostly legal opcodes with biased operands; a few unknown opcodes as noise
   function automatic logic [31:0] random_instruction();
      logic [7:0]  opcode;
      logic [3:0]  rd, rs;
      logic [15:0] low;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 2) opcode = 8'($urandom_range(255));
      else if (pick < 25) opcode = OP_WRITE;
      else opcode = known_ops[4'($urandom_range(11))];
      rd = 4'($urandom_range(15));
      rs = 4'($urandom_range(15));
      case ($urandom_range(7))
         0:       low = 16'h0000;
         1:       low = 16'hFFFF;
         2:       low = 16'h0001;
         3:       low = 16'($urandom_range(15));
         4:       low = 16'h8000;
         default: low = 16'($urandom);
      endcase
      return {opcode, rd, rs, low};
   endfunction

   // Offer one request; called just after a falling edge, returns after one
   task automatic send_request(input logic [31:0] instr, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_instruction     <= instr;
      req_last_of_program <= last;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(instr, last);
      @(negedge clock);
   endtask

   // Stop offering and let every outstanding response come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_results.size() != 0) @(negedge clock);
   endtask

   // Send random programs until enough non-ignored requests have gone in
   task automatic run_programs(input int target, input bit with_hold);
      int          sent;
      int          prog_len;
      bit          live;
      logic [31:0] instr;
      sent = 0;
      while (sent < target) begin
         prog_len = $urandom_range(1, 24);
         for (int i = 0; i < prog_len; i++) begin
            if (with_hold && sent == 80) hold_left = 300;
            instr = random_instruction();
            live  = !tracker.halted;
            send_request(instr, i == prog_len - 1);
            if (live) sent++;
         end
      end
   endtask

   // Stimulus
   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed program: extremes, every opcode, special cases
      send_request(encode(OP_MOVHI, 1, 0, 16'h8000), 1'b0);   // r1 = most negative
      send_request(encode(OP_SUBI, 2, 0, 16'h0001), 1'b0);    // r2 = -1
      send_request(encode(OP_DIV, 3, 1, 16'hFFF2), 1'b0);     // upper index bits ignored
      send_request(encode(OP_WRITE, 3, 0, 16'h0000), 1'b0);   // min / -1 wraps
      send_request(encode(OP_SUBI, 6, 0, 16'h0007), 1'b0);    // r6 = -7
      send_request(encode(OP_DIVI, 7, 6, 16'h0002), 1'b0);    // truncates to -3
      send_request(encode(OP_WRITE, 7, 0, 16'h0000), 1'b0);
      send_request(encode(OP_MOVLI, 8, 0, 16'h1234), 1'b0);
      send_request(encode(OP_DIVI, 8, 1, 16'h0000), 1'b0);    // zero immediate divisor
      send_request(encode(OP_DIV, 8, 1, 16'h0009), 1'b0);     // zero register divisor
      send_request(encode(OP_WRITE, 8, 0, 16'h0000), 1'b0);   // left unchanged
      send_request(encode(OP_MOV, 9, 2, 16'h0000), 1'b0);
      send_request(encode(OP_ADD, 10, 9, 16'h0001), 1'b0);    // -1 + min wraps
      send_request(encode(OP_ADDI, 11, 2, 16'hFFFF), 1'b0);
      send_request(encode(OP_SUB, 12, 1, 16'h0008), 1'b0);
      send_request(encode(OP_MUL, 13, 1, 16'h0002), 1'b0);
      send_request(encode(OP_MULI, 14, 2, 16'hFFFF), 1'b0);
      send_request(encode(OP_MOVHI, 15, 0, 16'hFFFF), 1'b0);
      send_request(encode(OP_MOVLI, 15, 0, 16'hFFFF), 1'b0);
      send_request(encode(OP_WRITE, 10, 0, 16'h0000), 1'b0);
      send_request(encode(OP_WRITE, 15, 0, 16'hFFFF), 1'b0);
      send_request(encode(8'hFF, 15, 15, 16'hFFFF), 1'b0);    // unknown opcode halts
      send_request(encode(OP_WRITE, 1, 0, 16'h0000), 1'b1);   // ignored, ends program
      send_request(encode(OP_WRITE, 1, 0, 16'h0000), 1'b0);   // registers were cleared
      send_request(encode(8'h00, 0, 0, 16'h0000), 1'b1);      // unknown, then cleared
      drain();

      // Random phases with different idle and stall mixes
      sender_idle_pct = 0;  receiver_stall_pct = 0;
      run_programs(275, 1'b1);
      drain();
      sender_idle_pct = 64; receiver_stall_pct = 0;
      run_programs(275, 1'b0);
      drain();
      sender_idle_pct = 0;  receiver_stall_pct = 64;
      run_programs(275, 1'b0);
      drain();
      sender_idle_pct = 32; receiver_stall_pct = 32;
      run_programs(275, 1'b0);
      drain();

      repeat (50) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
